// ===== sv/lcns_pkg.sv =====
// ----------------------------------------------------------------------------
// lcns_pkg: shared types and constants of the loop candidate nearest search
// Frame record layout, status codes, register map and datapath widths.
// ----------------------------------------------------------------------------
package lcns_pkg;

    // Table geometry
    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = IDX_W + 1;

    // Field widths
    localparam int POS_W  = 24;
    localparam int TRV_W  = 32;
    localparam int DIST_W = 52;
    localparam int HW_W   = 7;
    localparam int ST_W   = 2;

    // Squared-distance datapath: difference, one square, sum of three squares
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * POS_W;
    localparam int ACC_W  = SQ_W + 2;

    // Register port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam int RIDX_W = 2;

    localparam logic [RIDX_W-1:0] REG_RADIUS_SQ = 2'd0;
    localparam logic [RIDX_W-1:0] REG_GAP_MIN   = 2'd1;
    localparam logic [RIDX_W-1:0] REG_HALF_W    = 2'd2;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored key frame
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [TRV_W-1:0]        travel;
    } t_frame;

    // Control of the squared-distance unit
    typedef struct packed {
        logic en;     // operand pair valid this cycle
        logic first;  // first axis of a frame: restart the sum
    } t_sq_ctl;

endpackage

// ===== sv/loop_candidate_nearest_search_top.sv =====
// ----------------------------------------------------------------------------
// loop_candidate_nearest_search_top: loop candidate nearest search
// Key-frame table with append and radius nearest-neighbor search.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// request   in         i_in_valid/o_in_stall  command, pos_x/y/z, travelled
// result    out        o_out_valid/i_out_stall status, found, match, region
// config    in         psel/penable/pwrite    paddr, pwdata, prdata
//
// An append or a search on an empty table completes in the cycle it is taken.
// A search reads the newest frame as its query, then per stored frame does one
// table read, three axes through the single shared square-and-add unit, one compare.
// The block takes no request while a search runs or a result waits stalled.
// Reset clears the frame count and the registers; table contents stay unknown.
// ----------------------------------------------------------------------------
module loop_candidate_nearest_search_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  logic signed [lcns_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [lcns_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [lcns_pkg::POS_W-1:0]  i_pos_z,
    input  logic [lcns_pkg::TRV_W-1:0]         i_travelled,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [lcns_pkg::ST_W-1:0]          o_status,
    output logic                               o_found,
    output logic [lcns_pkg::IDX_W-1:0]         o_match_index,
    output logic [lcns_pkg::DIST_W-1:0]        o_match_dist_sq,
    output logic [lcns_pkg::IDX_W-1:0]         o_region_first,
    output logic [lcns_pkg::IDX_W-1:0]         o_region_last,
    output logic [lcns_pkg::IDX_W-1:0]         o_newest_index,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lcns_pkg::ADDR_W-1:0]        paddr,
    input  logic [lcns_pkg::DATA_W-1:0]        pwdata,
    output logic [lcns_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import lcns_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_QRD  = 9'b000000010,
        S_QCAP = 9'b000000100,
        S_X    = 9'b000001000,
        S_Y    = 9'b000010000,
        S_Z    = 9'b000100000,
        S_W    = 9'b001000000,
        S_C    = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state              r_state;
    t_state              n_state;

    // Registers
    logic [DIST_W-1:0]   r_radius_sq;
    logic [TRV_W-1:0]    r_gap_min;
    logic [HW_W-1:0]     r_half_w;
    logic [RIDX_W-1:0]   w_reg_idx;
    logic                w_cfg_wr;

    // Table and search state
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    w_count_m1;
    logic                w_full;
    logic [IDX_W-1:0]    r_q;
    logic [IDX_W-1:0]    r_i;
    logic signed [POS_W-1:0] r_qx;
    logic signed [POS_W-1:0] r_qy;
    logic signed [POS_W-1:0] r_qz;
    logic [TRV_W-1:0]    r_qt;
    logic                r_skip;
    logic                r_have;
    logic [IDX_W-1:0]    r_best;
    logic [ACC_W-1:0]    r_best_d;

    // Handshake
    logic                w_in_acc;
    logic                w_out_free;
    logic                r_out_valid;

    // Table ports
    logic                w_wr_en;
    t_frame              w_wr_data;
    logic                w_rd_en;
    logic [IDX_W-1:0]    w_rd_addr;
    t_frame              w_rd;

    // Shared unit
    t_sq_ctl             w_sq_ctl;
    logic signed [POS_W-1:0] w_sq_a;
    logic signed [POS_W-1:0] w_sq_b;
    logic [ACC_W-1:0]    w_acc;

    // Per-frame decisions
    logic signed [TRV_W:0] w_gap;
    logic                w_gap_short;
    logic                w_take;
    logic                w_scan_end;

    // Region bounds
    logic                w_first_ok;
    logic [IDX_W-1:0]    w_first;
    logic [CNT_W-1:0]    w_sum;
    logic [IDX_W-1:0]    w_last;

    logic                w_load;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:ADDR_W-RIDX_W];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_sq <= '0;
            r_gap_min   <= '0;
            r_half_w    <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_RADIUS_SQ: r_radius_sq <= pwdata[DIST_W-1:0];
                REG_GAP_MIN:   r_gap_min   <= pwdata[TRV_W-1:0];
                REG_HALF_W:    r_half_w    <= pwdata[HW_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back registers
    always_comb begin
        case (w_reg_idx)
            REG_RADIUS_SQ: prdata = DATA_W'(r_radius_sq);
            REG_GAP_MIN:   prdata = DATA_W'(r_gap_min);
            REG_HALF_W:    prdata = DATA_W'(r_half_w);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    assign w_full     = (r_count == CNT_W'(MAX_FRAMES));
    assign w_count_m1 = r_count - CNT_W'(1);

    // ------------------------------------------------------------------
    // Frame table
    // ------------------------------------------------------------------
    assign w_wr_en          = w_in_acc && !i_command && !w_full;
    assign w_wr_data.x      = i_pos_x;
    assign w_wr_data.y      = i_pos_y;
    assign w_wr_data.z      = i_pos_z;
    assign w_wr_data.travel = i_travelled;

    assign w_scan_end = (r_i == r_q);

    // Select the read address for the query and the walk
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_i;
        case (r_state)
            S_QRD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_q;
            end
            S_QCAP: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_i;
            end
            S_W: begin
                w_rd_en   = !w_scan_end;
                w_rd_addr = r_i + IDX_W'(1);
            end
            default: ;
        endcase
    end

    lcns_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd)
    );

    // ------------------------------------------------------------------
    // Shared squared-distance unit: one axis a cycle
    // ------------------------------------------------------------------
    always_comb begin
        w_sq_ctl.en    = 1'b0;
        w_sq_ctl.first = 1'b0;
        w_sq_a         = r_qx;
        w_sq_b         = w_rd.x;
        case (r_state)
            S_X: begin
                w_sq_ctl.en    = 1'b1;
                w_sq_ctl.first = 1'b1;
            end
            S_Y: begin
                w_sq_ctl.en = 1'b1;
                w_sq_a      = r_qy;
                w_sq_b      = w_rd.y;
            end
            S_Z: begin
                w_sq_ctl.en = 1'b1;
                w_sq_a      = r_qz;
                w_sq_b      = w_rd.z;
            end
            default: ;
        endcase
    end

    lcns_sq_unit u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sq_ctl),
        .i_a     (w_sq_a),
        .i_b     (w_sq_b),
        .o_acc   (w_acc)
    );

    // Travelled gap of the current frame, newest minus frame, signed
    assign w_gap       = $signed({1'b0, r_qt}) - $signed({1'b0, w_rd.travel});
    assign w_gap_short = w_gap < $signed({1'b0, r_gap_min});

    // Candidate not skipped for a short gap, inside the radius and strictly nearer than the best so far
    assign w_take = !r_skip && (DIST_W'(w_acc) < r_radius_sq)
                  && (!r_have || (w_acc < r_best_d));

    // Region around the match, clipped to the stored frames
    assign w_first_ok = {1'b0, r_best} >= CNT_W'(r_half_w);
    assign w_first    = w_first_ok ? (r_best - IDX_W'(r_half_w)) : '0;
    assign w_sum      = {1'b0, r_best} + CNT_W'(r_half_w);
    assign w_last     = (w_sum > {1'b0, r_q}) ? r_q : w_sum[IDX_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_command && (r_count != '0)) begin
                    n_state = S_QRD;
                end
            end
            S_QRD:  n_state = S_QCAP;
            S_QCAP: n_state = S_X;
            S_X:    n_state = S_Y;
            S_Y:    n_state = S_Z;
            S_Z:    n_state = S_W;
            S_W:    n_state = S_C;
            S_C:    n_state = w_scan_end ? S_DONE : S_X;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Frame count: advance on a stored append
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_wr_en) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Walk state and best candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            if (r_state == S_IDLE && w_in_acc && i_command) begin
                r_have <= 1'b0;
            end else if (r_state == S_C && w_take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q <= w_count_m1[IDX_W-1:0];
                r_i <= '0;
            end
            S_QCAP: begin
                r_qx <= w_rd.x;
                r_qy <= w_rd.y;
                r_qz <= w_rd.z;
                r_qt <= w_rd.travel;
            end
            S_X: begin
                r_skip <= w_gap_short;
            end
            S_C: begin
                if (w_take) begin
                    r_best   <= r_i;
                    r_best_d <= w_acc;
                end
                if (!w_scan_end) begin
                    r_i <= r_i + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    assign w_load = (r_state == S_IDLE && w_in_acc && !(i_command && (r_count != '0)))
                  || (r_state == S_DONE && w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_found         <= 1'b0;
            o_match_index   <= '0;
            o_match_dist_sq <= '0;
            o_region_first  <= '0;
            o_region_last   <= '0;
            o_newest_index  <= '0;
            o_status        <= ST_OK;
            if (r_state == S_DONE) begin
                o_newest_index <= r_q;
                if (r_have) begin
                    o_found         <= 1'b1;
                    o_match_index   <= r_best;
                    o_match_dist_sq <= DIST_W'(r_best_d);
                    o_region_first  <= w_first;
                    o_region_last   <= w_last;
                end
            end else if (i_command) begin
                o_status <= ST_EMPTY;
            end else if (w_full) begin
                o_status       <= ST_FULL;
                o_newest_index <= w_count_m1[IDX_W-1:0];
            end else begin
                o_match_index  <= r_count[IDX_W-1:0];
                o_newest_index <= r_count[IDX_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_FRAMES))
        else $error("frame count beyond table size");

    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_C) |-> (r_i <= r_q && {1'b0, r_q} < r_count))
        else $error("walk index outside stored frames");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_command && !w_full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("stored append did not advance the count");

    a_match_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_found) |-> (o_region_first <= o_match_index
            && o_region_last >= o_match_index && o_match_index <= o_newest_index
            && o_match_dist_sq < r_radius_sq))
        else $error("match outside region or radius");

endmodule

// ===== sv/lcns_frame_mem.sv =====
// ----------------------------------------------------------------------------
// lcns_frame_mem: key-frame table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lcns_frame_mem (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [lcns_pkg::IDX_W-1:0]  i_wr_addr,
    input  lcns_pkg::t_frame            i_wr_data,
    input  logic                        i_rd_en,
    input  logic [lcns_pkg::IDX_W-1:0]  i_rd_addr,
    output lcns_pkg::t_frame            o_rd_data
);
    import lcns_pkg::*;

    t_frame r_mem [MAX_FRAMES];
    t_frame r_rd_data;

    // Store appended frames
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one frame, hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/lcns_sq_unit.sv =====
// ----------------------------------------------------------------------------
// lcns_sq_unit: shared squared-distance unit
// Takes one axis pair a cycle, squares the difference and sums three axes.
// The sum is complete once the last axis has passed the product register into the accumulator.
// ----------------------------------------------------------------------------
module lcns_sq_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lcns_pkg::t_sq_ctl                 i_ctl,
    input  logic signed [lcns_pkg::POS_W-1:0] i_a,
    input  logic signed [lcns_pkg::POS_W-1:0] i_b,
    output logic [lcns_pkg::ACC_W-1:0]        o_acc
);
    import lcns_pkg::*;

    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [2*DIFF_W-1:0] w_sq;
    logic [SQ_W-1:0]            r_prod;
    logic                       r_pvalid;
    logic                       r_pfirst;
    logic [ACC_W-1:0]           r_acc;

    // Exact difference and its square
    assign w_diff = DIFF_W'(i_a) - DIFF_W'(i_b);
    assign w_sq   = w_diff * w_diff;

    // Product stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_pfirst <= 1'b0;
        end else begin
            r_pvalid <= i_ctl.en;
            r_pfirst <= i_ctl.first;
        end
    end

    // Product register
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= w_sq[SQ_W-1:0];
        end
    end

    // Accumulate the axes of one frame
    always_ff @(posedge i_clk) begin
        if (r_pvalid) begin
            r_acc <= (r_pfirst ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule
